>>> design/psb_pkg.sv
// shared types and constants of the pixel scale to byte unit
package psb_pkg;

  // widths fixed by the sample format and the largest table depth
  localparam int NUM_W = 52;
  localparam int DEN_W = 36;
  localparam int TOP_W = 16;
  localparam int TIDX_W = 10;
  localparam int BYTE_W = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int QUEUE_DEPTH = 4;

  localparam int LUT_DEPTH_DEF = 1024;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_TYPE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LUT_ENABLE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MAX   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LUT_SIZE    = 3'd4;

  localparam logic [1:0] ST_BYTE    = 2'd0;
  localparam logic [1:0] ST_FLOAT   = 2'd1;
  localparam logic [1:0] ST_COMPLEX = 2'd2;

  typedef enum logic [2:0] {
    K_WRITE,
    K_LINEAR,
    K_LOOKUP,
    K_COMPLEX,
    K_ZERO
  } psb_kind_e;

  typedef struct packed {
    psb_kind_e           kind;
    logic                last;
    logic                pos1;
    logic                pos2;
    logic [NUM_W-1:0]    num1;
    logic [NUM_W-1:0]    num2;
    logic [DEN_W-1:0]    den;
    logic [TOP_W-1:0]    top;
    logic                wen;
    logic [TIDX_W-1:0]   widx;
    logic [BYTE_W-1:0]   wval;
  } psb_item_t;

endpackage

>>> design/psb_front.sv
// front part: configuration registers, item classification and ratio set-up
module psb_front import psb_pkg::*; #(
  parameter int LUT_DEPTH = LUT_DEPTH_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  op_i,
  input  logic [31:0]           sample_real_i,
  input  logic [31:0]           sample_imag_i,
  input  logic [TIDX_W-1:0]     table_index_i,
  input  logic [BYTE_W-1:0]     table_value_i,
  input  logic                  end_of_tile_i,
  output logic                  push_o,
  input  logic                  full_i,
  output psb_item_t             item_o
);

  localparam int SZW = $clog2(LUT_DEPTH + 1);

  logic [1:0]  sample_type_q;
  logic        lut_enable_q;
  logic [31:0] range_min_q;
  logic [31:0] range_max_q;
  logic [10:0] lut_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_type_q <= '0;
      lut_enable_q  <= 1'b0;
      range_min_q   <= '0;
      range_max_q   <= 32'h00FF_0000;
      lut_size_q    <= 11'd256;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SAMPLE_TYPE: sample_type_q <= cfg_data_i[1:0];
        CFG_LUT_ENABLE:  lut_enable_q  <= cfg_data_i[0];
        CFG_RANGE_MIN:   range_min_q   <= cfg_data_i;
        CFG_RANGE_MAX:   range_max_q   <= cfg_data_i;
        CFG_LUT_SIZE:    lut_size_q    <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  logic [SZW-1:0]     sz;
  logic signed [32:0] d, r;
  logic signed [33:0] dn, rn;
  logic signed [17:0] k;
  logic signed [51:0] prod;
  logic signed [34:0] a, b, den0, aa, bb, denc;
  logic signed [44:0] s1, s2, n1, n2;
  psb_item_t          item;

  always_comb begin
    if (lut_size_q == 11'd0) begin
      sz = SZW'(1);
    end else if (32'(lut_size_q) > 32'(LUT_DEPTH)) begin
      sz = SZW'(LUT_DEPTH);
    end else begin
      sz = SZW'(lut_size_q);
    end

    // real path
    d  = $signed({sample_real_i[31], sample_real_i}) - $signed({range_min_q[31], range_min_q});
    r  = $signed({range_max_q[31], range_max_q}) - $signed({range_min_q[31], range_min_q});
    dn = (r < 0) ? -34'(d) : 34'(d);
    rn = (r < 0) ? -34'(r) : 34'(r);
    if (r == 0) begin
      k = 18'sd1;
    end else if (lut_enable_q) begin
      k = 18'(sz);
    end else begin
      k = 18'sd255;
    end
    prod = dn * k;

    // complex path, flipped signs for a negative scale
    a = 35'(signed'(sample_real_i));
    b = 35'(signed'(sample_imag_i));
    if (range_max_q == 32'd0) begin
      den0 = 35'(1) <<< FRAC_BITS;
    end else begin
      den0 = $signed({{2{range_max_q[31]}}, range_max_q, 1'b0});
      if (den0 < 0) begin
        den0 = -den0;
        a    = -a;
        b    = -b;
      end
    end
    aa = ((a < 0) ? -a : a) <<< 1;
    bb = ((b < 0) ? -b : b) <<< 1;
    denc = den0;
    if (aa > denc) denc = aa;
    if (bb > denc) denc = bb;
    s1 = (a <<< 1) + denc;
    s2 = (b <<< 1) + denc;
    n1 = (s1 <<< 8) - s1;
    n2 = (s2 <<< 8) - s2;

    item      = '0;
    item.last = end_of_tile_i;
    item.widx = table_index_i;
    item.wval = table_value_i;
    item.wen  = 32'(table_index_i) < 32'(LUT_DEPTH);
    if (op_i) begin
      item.kind = K_WRITE;
    end else if (sample_type_q == ST_BYTE || sample_type_q == ST_FLOAT) begin
      item.kind = lut_enable_q ? K_LOOKUP : K_LINEAR;
      item.num1 = NUM_W'(prod);
      item.pos1 = prod > 0;
      item.den  = (r == 0) ? (DEN_W'(1) << FRAC_BITS) : DEN_W'(rn);
      item.top  = lut_enable_q ? TOP_W'(sz - SZW'(1)) : TOP_W'(255);
    end else if (sample_type_q == ST_COMPLEX) begin
      item.kind = K_COMPLEX;
      item.num1 = NUM_W'(n1);
      item.num2 = NUM_W'(n2);
      item.pos1 = n1 > 0;
      item.pos2 = n2 > 0;
      item.den  = DEN_W'(denc) << 1;
      item.top  = TOP_W'(255);
    end else begin
      item.kind = K_ZERO;
    end
  end

  logic      fv_q;
  psb_item_t fitem_q;

  assign push_o     = fv_q && !full_i;
  assign in_ready_o = !fv_q || !full_i;
  assign item_o     = fitem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      fv_q <= 1'b1;
    end else if (push_o) begin
      fv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      fitem_q <= item;
    end
  end

endmodule

>>> design/psb_queue.sv
// short queue between the front and back parts
module psb_queue import psb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  psb_item_t data_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output psb_item_t data_o
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  psb_item_t   mem_q [QUEUE_DEPTH];
  logic [PW-1:0] wp_q, rp_q;
  logic [PW:0]   cnt_q;

  assign full_o  = cnt_q == (PW+1)'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + PW'(1);
      if (pop_i)  rp_q <= rp_q + PW'(1);
      cnt_q <= cnt_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

endmodule

>>> design/psb_back.sv
// back part: pipelined dividers, table store and output register
module psb_back import psb_pkg::*; #(
  parameter int LUT_DEPTH = LUT_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  psb_item_t         item_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [BYTE_W-1:0] byte_first_o,
  output logic [BYTE_W-1:0] byte_second_o,
  output logic              tile_last_o
);

  localparam int QW = $clog2((LUT_DEPTH > 256) ? LUT_DEPTH : 256);
  localparam int AW = $clog2(LUT_DEPTH);
  localparam int WW = NUM_W + QW;

  typedef struct packed {
    psb_kind_e         kind;
    logic              last;
    logic              pos1;
    logic              pos2;
    logic              ovf1;
    logic              ovf2;
    logic [NUM_W-1:0]  rem1;
    logic [NUM_W-1:0]  rem2;
    logic [QW-1:0]     q1;
    logic [QW-1:0]     q2;
    logic [DEN_W-1:0]  den;
    logic [QW-1:0]     top;
    logic              wen;
    logic [TIDX_W-1:0] widx;
    logic [BYTE_W-1:0] wval;
  } stage_t;

  logic   adv;
  logic   [QW:0] vld_q;
  stage_t st_q [QW+1];
  stage_t entry;

  assign adv   = !out_valid_o || out_ready_i;
  assign pop_o = adv && !empty_i;

  always_comb begin
    entry      = '0;
    entry.kind = item_i.kind;
    entry.last = item_i.last;
    entry.pos1 = item_i.pos1;
    entry.pos2 = item_i.pos2;
    entry.rem1 = item_i.num1;
    entry.rem2 = item_i.num2;
    entry.den  = item_i.den;
    entry.top  = QW'(item_i.top);
    entry.wen  = item_i.wen;
    entry.widx = item_i.widx;
    entry.wval = item_i.wval;
    // quotient too wide for QW bits saturates
    entry.ovf1 = WW'(item_i.num1) >= (WW'(item_i.den) << QW);
    entry.ovf2 = WW'(item_i.num2) >= (WW'(item_i.den) << QW);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[QW-1:0], !empty_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) st_q[0] <= entry;
  end

  // one quotient bit per stage, most significant first
  for (genvar g = 0; g < QW; g++) begin : g_div
    localparam int BIT = QW - 1 - g;
    logic [WW-1:0] dsh;
    stage_t        nx;
    always_comb begin
      dsh = WW'(st_q[g].den) << BIT;
      nx  = st_q[g];
      if (WW'(st_q[g].rem1) >= dsh) begin
        nx.rem1   = NUM_W'(WW'(st_q[g].rem1) - dsh);
        nx.q1[BIT] = 1'b1;
      end
      if (WW'(st_q[g].rem2) >= dsh) begin
        nx.rem2   = NUM_W'(WW'(st_q[g].rem2) - dsh);
        nx.q2[BIT] = 1'b1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) st_q[g+1] <= nx;
    end
  end

  stage_t        fin;
  logic [QW-1:0] qc1, qc2;

  assign fin = st_q[QW];

  always_comb begin
    if (!fin.pos1) begin
      qc1 = '0;
    end else if (fin.ovf1 || fin.q1 > fin.top) begin
      qc1 = fin.top;
    end else begin
      qc1 = fin.q1;
    end
    if (!fin.pos2) begin
      qc2 = '0;
    end else if (fin.ovf2 || fin.q2 > fin.top) begin
      qc2 = fin.top;
    end else begin
      qc2 = fin.q2;
    end
  end

  logic [BYTE_W-1:0] lut_q [LUT_DEPTH];
  logic [BYTE_W-1:0] rdata_q;
  logic              rd_vld_q;
  psb_kind_e         rd_kind_q;
  logic              rd_last_q;
  logic [BYTE_W-1:0] rd_b1_q, rd_b2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (vld_q[QW] && fin.kind == K_WRITE && fin.wen) begin
        lut_q[AW'(32'(fin.widx))] <= fin.wval;
      end
      rdata_q   <= lut_q[AW'(qc1)];
      rd_kind_q <= fin.kind;
      rd_last_q <= fin.last;
      rd_b1_q   <= qc1[BYTE_W-1:0];
      rd_b2_q   <= qc2[BYTE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q    <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (adv) begin
      rd_vld_q    <= vld_q[QW] && fin.kind != K_WRITE;
      out_valid_o <= rd_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tile_last_o <= rd_last_q;
      unique case (rd_kind_q)
        K_LINEAR: begin
          byte_first_o  <= rd_b1_q;
          byte_second_o <= '0;
        end
        K_LOOKUP: begin
          byte_first_o  <= rdata_q;
          byte_second_o <= '0;
        end
        K_COMPLEX: begin
          byte_first_o  <= rd_b1_q;
          byte_second_o <= rd_b2_q;
        end
        default: begin
          byte_first_o  <= '0;
          byte_second_o <= '0;
        end
      endcase
    end
  end

endmodule

>>> design/pixel_scale_to_byte_unit.sv
// top level of the pixel scale to byte unit
//
// channel   dir  handshake               payload
// s_axis    in   s_axis_tvalid/tready    tdata: sample, table entry; tuser: op; tlast
// m_axis    out  m_axis_tvalid/tready    tdata: byte_first, byte_second; tlast
// cfg       in   cfg_we_i                cfg_idx_i, cfg_data_i
//
// one word per cycle sustained while the output takes words; the latency is set by the
// divider pipeline, one quotient bit per stage
// table writes travel down the same pipeline, so they stay in order with reads
// reset clears control state only; the table holds nothing until written
// an output stall holds the back pipeline; the queue then fills and stalls the input
module pixel_scale_to_byte_unit import psb_pkg::*; #(
  parameter int LUT_DEPTH = LUT_DEPTH_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // sample_real [31:0], sample_imag [63:32], table_index [73:64], table_value [81:74]
  input  logic [87:0]           s_axis_tdata,
  // op [0]
  input  logic                  s_axis_tuser,
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // byte_first [7:0], byte_second [15:8]
  output logic [15:0]           m_axis_tdata,
  output logic                  m_axis_tlast
);

  logic      push, full, pop, empty;
  psb_item_t f_item, q_item;
  logic [BYTE_W-1:0] b1, b2;

  // accepts and classifies words, sets up the ratios
  psb_front #(
    .LUT_DEPTH (LUT_DEPTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .op_i          (s_axis_tuser),
    .sample_real_i (s_axis_tdata[31:0]),
    .sample_imag_i (s_axis_tdata[63:32]),
    .table_index_i (s_axis_tdata[73:64]),
    .table_value_i (s_axis_tdata[81:74]),
    .end_of_tile_i (s_axis_tlast),
    .push_o        (push),
    .full_i        (full),
    .item_o        (f_item)
  );

  psb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (f_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (q_item)
  );

  // divides, clamps, looks up and drives the output register
  psb_back #(
    .LUT_DEPTH (LUT_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .item_i        (q_item),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .byte_first_o  (b1),
    .byte_second_o (b2),
    .tile_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {b2, b1};

endmodule

>>> verif/pixel_scale_to_byte_unit_checker.sv
// scoreboard that predicts and checks the display bytes of the pixel scale unit
`timescale 1ns / 1ps
module pixel_scale_to_byte_unit_checker import psb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_valid_i,
  input  logic                  s_ready_i,
  input  logic [87:0]           s_data_i,
  input  logic                  s_user_i,
  input  logic                  s_last_i,
  input  logic                  m_valid_i,
  input  logic                  m_ready_i,
  input  logic [15:0]           m_data_i,
  input  logic                  m_last_i,
  output int                    errors_o,
  output int                    pending_o
);

  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
    logic       last;
  } disp_t;

  logic [1:0]  kind_q;
  logic        lut_on_q;
  logic [31:0] lo_q, hi_q;
  logic [10:0] size_q;
  logic [7:0]  shade [1024];
  disp_t       due_q [$];

  function automatic longint floor_clamp(longint num, longint den, longint top);
    longint q;
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    if (num <= 0) return 0;
    q = num / den;
    return q > top ? top : q;
  endfunction

  function automatic longint unit_floor(longint d, longint top);
    longint q;
    if (d <= 0) return 0;
    q = d >>> 16;
    return q > top ? top : q;
  endfunction

  function automatic logic [7:0] iq_byte(longint a, longint den);
    longint num;
    longint q;
    num = (2 * a + den) * 255;
    if (num <= 0) return '0;
    q = num / (2 * den);
    return q > 255 ? 8'd255 : q[7:0];
  endfunction

  function automatic disp_t pixel_bytes(logic [31:0] re, logic [31:0] im, logic tl);
    disp_t  r;
    longint xr, xq, mn, mx, d, span, sz, idx, den;
    r = '0;
    r.last = tl;
    xr = longint'($signed(re));
    xq = longint'($signed(im));
    mn = longint'($signed(lo_q));
    mx = longint'($signed(hi_q));
    if (kind_q == ST_BYTE || kind_q == ST_FLOAT) begin
      d = xr - mn;
      span = mx - mn;
      if (lut_on_q) begin
        sz = size_q;
        if (sz < 1) sz = 1;
        if (sz > 1024) sz = 1024;
        idx = (span == 0) ? unit_floor(d, sz - 1) : floor_clamp(d * sz, span, sz - 1);
        r.first = shade[idx];
      end else begin
        r.first = 8'((span == 0) ? unit_floor(d, 255) : floor_clamp(d * 255, span, 255));
      end
    end else if (kind_q == ST_COMPLEX) begin
      if (mx == 0) den = 64'd1 << 16;
      else begin
        den = 2 * mx;
        if (den < 0) begin
          den = -den;
          xr = -xr;
          xq = -xq;
        end
      end
      if (2 * (xr < 0 ? -xr : xr) > den) den = 2 * (xr < 0 ? -xr : xr);
      if (2 * (xq < 0 ? -xq : xq) > den) den = 2 * (xq < 0 ? -xq : xq);
      r.first = iq_byte(xr, den);
      r.second = iq_byte(xq, den);
    end
    return r;
  endfunction

  assign pending_o = due_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    disp_t want;
    int    errs;
    errs = 0;
    if (!rst_ni) begin
      kind_q <= ST_BYTE;
      lut_on_q <= 1'b0;
      lo_q <= '0;
      hi_q <= 32'h00FF0000;
      size_q <= 11'd256;
      errors_o <= 0;
      due_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SAMPLE_TYPE: kind_q <= cfg_data_i[1:0];
          CFG_LUT_ENABLE:  lut_on_q <= cfg_data_i[0];
          CFG_RANGE_MIN:   lo_q <= cfg_data_i;
          CFG_RANGE_MAX:   hi_q <= cfg_data_i;
          CFG_LUT_SIZE:    size_q <= cfg_data_i[10:0];
          default: ;
        endcase
      end
      if (s_valid_i && s_ready_i) begin
        if (s_user_i) shade[s_data_i[73:64]] = s_data_i[81:74];
        else due_q.push_back(pixel_bytes(s_data_i[31:0], s_data_i[63:32], s_last_i));
      end
      if (m_valid_i && m_ready_i) begin
        if (due_q.size() == 0) begin
          $error("unexpected word %h", m_data_i);
          errs++;
        end else begin
          want = due_q.pop_front();
          if (m_data_i[7:0] !== want.first) begin
            $error("byte_first exp %0d got %0d", want.first, m_data_i[7:0]);
            errs++;
          end
          if (m_data_i[15:8] !== want.second) begin
            $error("byte_second exp %0d got %0d", want.second, m_data_i[15:8]);
            errs++;
          end
          if (m_last_i !== want.last) begin
            $error("tile_last exp %0d got %0d", want.last, m_last_i);
            errs++;
          end
        end
      end
      errors_o <= errors_o + errs;
    end
  end

endmodule

>>> verif/pixel_scale_to_byte_unit_tb.sv
// stimulus and verdict for the pixel scale to byte unit
`timescale 1ns / 1ps
module pixel_scale_to_byte_unit_tb;
  import psb_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_WAIT = 40;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // sample_real [31:0], sample_imag [63:32], table_index [73:64], table_value [81:74]
  logic [87:0]           s_axis_tdata = '0;
  // op [0]
  logic                  s_axis_tuser = 1'b0;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // byte_first [7:0], byte_second [15:8]
  logic [15:0]           m_axis_tdata;
  logic                  m_axis_tlast;

  int errors, pending, idle_cycles;
  bit hold_out = 1'b0;

  // number of table entries written so far
  int        shade_cap;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  pixel_scale_to_byte_unit dut (.*);

  pixel_scale_to_byte_unit_checker u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_valid_i(s_axis_tvalid), .s_ready_i(s_axis_tready), .s_data_i(s_axis_tdata),
    .s_user_i(s_axis_tuser), .s_last_i(s_axis_tlast),
    .m_valid_i(m_axis_tvalid), .m_ready_i(m_axis_tready), .m_data_i(m_axis_tdata),
    .m_last_i(m_axis_tlast), .errors_o(errors), .pending_o(pending)
  );

  // receiver: own stall pattern, plus a long hold-off when asked
  initial begin
    int mode;
    forever begin
      @(posedge clk_i);
      if (hold_out) m_axis_tready <= 1'b0;
      else begin
        mode = ($urandom_range(0, 299) / 100);
        if (mode == 0) m_axis_tready <= 1'b1;
        else if (mode == 1) m_axis_tready <= ($urandom_range(0, 3) != 0);
        else m_axis_tready <= ($urandom_range(0, 2) == 0);
      end
    end
  end

  // watchdog on accepted words
  initial begin
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i
          || hold_out || !rst_ni)
        idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // one word on the input, kept offered until taken
  task automatic push_word(bit op, logic [31:0] re, logic [31:0] im,
                           logic [9:0] tidx, logic [7:0] tval, bit tl);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tlast <= tl;
    s_axis_tdata <= {6'd0, tval, tidx, im, re};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic rest(int n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic pixel(logic [31:0] re, logic [31:0] im);
    push_word(1'b0, re, im, 10'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
  endtask

  task automatic fill_shade(int n);
    for (int i = 0; i < n; i++)
      push_word(1'b1, $urandom, $urandom, 10'(i), 8'($urandom), 1'($urandom));
  endtask

  // wait for all results, then a further wait for trailing table writes in the pipeline
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // registers change only with the unit empty
  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_all(logic [1:0] st, bit lut, logic [31:0] lo, logic [31:0] hi,
                         logic [10:0] sz);
    drain();
    set_reg(CFG_SAMPLE_TYPE, 32'(st));
    set_reg(CFG_LUT_ENABLE, 32'(lut));
    set_reg(CFG_RANGE_MIN, lo);
    set_reg(CFG_RANGE_MAX, hi);
    set_reg(CFG_LUT_SIZE, 32'(sz));
  endtask

  function automatic logic [31:0] near(logic [31:0] base);
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return base + $urandom_range(0, 65535) - 32768;
      2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      default: return base + ($urandom_range(0, 511) << 16) - (32'd256 << 16);
    endcase
  endfunction

  // random phase with burst and gap pacing on the sender
  task automatic random_phase(int n, logic [31:0] lo, logic [31:0] hi);
    int burst;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 30);
        if ($urandom_range(0, 2) == 0) rest($urandom_range(1, 8));
      end
      burst--;
      if ($urandom_range(0, 15) == 0)
        push_word(1'b1, $urandom, $urandom, 10'($urandom_range(0, shade_cap - 1)),
                  8'($urandom), 1'($urandom));
      else pixel(near($urandom_range(0, 1) ? lo : hi), near(hi));
    end
  endtask

  initial begin
    logic [31:0] lo, hi;
    logic [10:0] sz;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // table fully written so any index is safe in lookup mode
    fill_shade(1024);
    shade_cap = 1024;

    // directed: extremes at reset settings
    pixel(32'h0, 32'h0);
    pixel(32'h7FFFFFFF, 32'h80000000);
    pixel(32'h80000000, 32'h7FFFFFFF);
    pixel(32'h00FF0000, 32'h0);
    pixel(32'h00FEFFFF, 32'h0);
    // equal limits
    set_all(ST_FLOAT, 1'b0, 32'h00010000, 32'h00010000, 11'd256);
    pixel(32'h00050000, 0); pixel(32'h7FFFFFFF, 0); pixel(32'h0, 0);
    set_reg(CFG_LUT_ENABLE, 32'd1);
    pixel(32'h00050000, 0); pixel(32'h7FFFFFFF, 0);
    // table size edges: zero acts as one, oversize acts as full depth
    set_all(ST_BYTE, 1'b1, 32'h80000000, 32'h7FFFFFFF, 11'd0);
    pixel(32'h7FFFFFFF, 0); pixel(32'h0, 0);
    set_reg(CFG_LUT_SIZE, 32'h7FF);
    pixel(32'h7FFFFFFF, 0); pixel(32'h80000000, 0); pixel(32'h12345678, 0);
    // inverted limits
    set_all(ST_BYTE, 1'b0, 32'h00FF0000, 32'h0, 11'd1024);
    pixel(32'h00100000, 0); pixel(32'h7FFFFFFF, 0);
    // complex: zero, negative and most negative max
    set_all(ST_COMPLEX, 1'b1, 32'h0, 32'h0, 11'd1024);
    pixel(32'h00008000, 32'hFFFF8000); pixel(32'h7FFFFFFF, 32'h80000000);
    set_reg(CFG_RANGE_MAX, 32'hFFFE0000);
    pixel(32'h00010000, 32'h00004000); pixel(32'h80000000, 32'h7FFFFFFF);
    set_reg(CFG_RANGE_MAX, 32'h80000000);
    pixel(32'h00010000, 32'hFFFF0000);
    // unhandled type, lookup on and off
    set_all(2'd3, 1'b1, 32'h0, 32'h00FF0000, 11'd256);
    pixel(32'h00100000, 32'h1);
    set_reg(CFG_LUT_ENABLE, 32'd0);
    pixel(32'h00100000, 32'h1);

    // long hold-off on the receiver while the sender keeps offering
    set_all(ST_BYTE, 1'b0, 32'h0, 32'h00FF0000, 11'd256);
    hold_out = 1'b1;
    fork
      random_phase(60, 32'h0, 32'h00FF0000);
      begin
        repeat (300) @(posedge clk_i);
        hold_out = 1'b0;
      end
    join
    // sender pauses until everything is back
    drain();

    // random phases across settings
    for (int p = 0; p < 12; p++) begin
      lo = $urandom_range(0, 3) == 0 ? 32'h80000000 : $urandom >>> $urandom_range(0, 12);
      hi = $urandom_range(0, 3) == 0 ? 32'h7FFFFFFF : $urandom >>> $urandom_range(0, 12);
      if ($urandom_range(0, 7) == 0) hi = lo;
      if ($urandom_range(0, 7) == 0) hi = 32'h0;
      sz = ($urandom_range(0, 5) == 0) ? 11'($urandom) : 11'($urandom_range(1, 64));
      set_all(2'($urandom), 1'($urandom), lo, hi, sz);
      random_phase(70, lo, hi);
    end

    drain();
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
